[hw/rtl/date_time_field_stepper_core_macros.svh]
// ----------------------------------------------------------------------------
// date_time_field_stepper_core_macros
// assertion helpers for the date-time field stepper, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef DATE_TIME_FIELD_STEPPER_CORE_MACROS_SVH
`define DATE_TIME_FIELD_STEPPER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define DTFS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtfs assertion failed");
// next-cycle implication, disabled while in reset
`define DTFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtfs assertion failed");
`else
`define DTFS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define DTFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/dtfs_pkg.sv]
// ----------------------------------------------------------------------------
// dtfs_pkg
// shared types, tables and calendar helpers for the date-time field stepper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtfs_pkg;

    // field selector codes, the two remaining codes are unused selectors
    typedef enum logic [2:0] {
        OP_YEAR   = 3'd0,
        OP_MONTH  = 3'd1,
        OP_DAY    = 3'd2,
        OP_HOUR   = 3'd3,
        OP_MINUTE = 3'd4,
        OP_SECOND = 3'd5
    } op_t;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } stamp_t;

    localparam logic [6:0] LAST_YEAR   = 7'd99;
    localparam logic [3:0] LAST_MONTH  = 4'd12;
    localparam logic [4:0] LAST_HOUR   = 5'd23;
    localparam logic [5:0] LAST_MINUTE = 6'd59;
    localparam logic [5:0] LAST_SECOND = 6'd59;

    // weekday offset per month (sakamoto style), indexed by month - 1
    localparam logic [2:0] DOW_OFF [12] = '{
        3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5, 3'd1, 3'd4, 3'd6, 3'd2, 3'd4
    };

    // days before each month in a common year, indexed by month - 1
    localparam logic [8:0] DAYS_BEFORE [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // within 2000..2099 every fourth year is leap, 2000 included
    function automatic logic is_leap(logic [6:0] yoff);
        return (yoff[1:0] == 2'b00);
    endfunction

    function automatic logic [4:0] month_days(logic [6:0] yoff, logic [3:0] mo);
        logic [4:0] len;
        unique case (mo)
            4'd2:                    len = is_leap(yoff) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

[hw/rtl/dtfs_step.sv]
// ----------------------------------------------------------------------------
// dtfs_step
// saturates the incoming date-time and applies one field step with carry; the seconds selector clears seconds
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtfs_step
(
    input  logic [2:0]      op,
    input  logic            direction,
    input  dtfs_pkg::stamp_t in_stamp,
    output dtfs_pkg::stamp_t out_stamp
);

    dtfs_pkg::stamp_t sat;
    dtfs_pkg::stamp_t day_up;
    dtfs_pkg::stamp_t day_dn;
    logic [6:0]       sat_year;
    logic [3:0]       sat_month;
    logic [4:0]       sat_len;
    logic [6:0]       y_inc;
    logic [6:0]       y_dec;
    logic [3:0]       mo_inc;
    logic [3:0]       mo_dec;
    logic [6:0]       yr_new;
    logic [4:0]       yr_len;
    logic [3:0]       mo_new;
    logic [4:0]       mo_len;
    logic [6:0]       prev_year;
    logic [4:0]       prev_len;

    // year and month saturate first, the day clamp needs both
    assign sat_year  = (in_stamp.year > dtfs_pkg::LAST_YEAR) ? dtfs_pkg::LAST_YEAR
                                                              : in_stamp.year;
    assign sat_month = (in_stamp.month == 4'd0) ? 4'd1 :
                       ((in_stamp.month > dtfs_pkg::LAST_MONTH) ? dtfs_pkg::LAST_MONTH
                                                                : in_stamp.month);
    assign sat_len   = dtfs_pkg::month_days(sat_year, sat_month);

    // saturate out-of-range fields
    always_comb
    begin
        sat       = in_stamp;
        sat.year  = sat_year;
        sat.month = sat_month;
        if (in_stamp.hour > dtfs_pkg::LAST_HOUR)
            sat.hour = dtfs_pkg::LAST_HOUR;
        if (in_stamp.minute > dtfs_pkg::LAST_MINUTE)
            sat.minute = dtfs_pkg::LAST_MINUTE;
        if (in_stamp.second > dtfs_pkg::LAST_SECOND)
            sat.second = dtfs_pkg::LAST_SECOND;
        if (in_stamp.day == 5'd0)
            sat.day = 5'd1;
        else if (in_stamp.day > sat_len)
            sat.day = sat_len;
    end

    // wrapping neighbours of year and month
    assign y_inc  = (sat.year >= dtfs_pkg::LAST_YEAR) ? 7'd0 : sat.year + 7'd1;
    assign y_dec  = (sat.year == 7'd0) ? dtfs_pkg::LAST_YEAR : sat.year - 7'd1;
    assign mo_inc = (sat.month == dtfs_pkg::LAST_MONTH) ? 4'd1 : sat.month + 4'd1;
    assign mo_dec = (sat.month == 4'd1) ? dtfs_pkg::LAST_MONTH : sat.month - 4'd1;

    // field steps clamp the day to the target month
    assign yr_new = direction ? y_dec : y_inc;
    assign yr_len = dtfs_pkg::month_days(yr_new, sat.month);
    assign mo_new = direction ? mo_dec : mo_inc;
    assign mo_len = dtfs_pkg::month_days(sat.year, mo_new);

    // previous day, borrowing into the previous month and year
    assign prev_year = (sat.month == 4'd1) ? y_dec : sat.year;
    assign prev_len  = dtfs_pkg::month_days(prev_year, mo_dec);

    always_comb
    begin
        day_dn = sat;
        if (sat.day > 5'd1)
            day_dn.day = sat.day - 5'd1;
        else
        begin
            day_dn.month = mo_dec;
            day_dn.year  = prev_year;
            day_dn.day   = prev_len;
        end
    end

    // next day, carrying into the next month and year
    always_comb
    begin
        day_up = sat;
        if (sat.day < sat_len)
            day_up.day = sat.day + 5'd1;
        else
        begin
            day_up.day   = 5'd1;
            day_up.month = mo_inc;
            if (sat.month == dtfs_pkg::LAST_MONTH)
                day_up.year = y_inc;
        end
    end

    always_comb
    begin
        out_stamp = sat;
        unique case (dtfs_pkg::op_t'(op))
            dtfs_pkg::OP_YEAR:
            begin
                out_stamp.year = yr_new;
                if (sat.day > yr_len)
                    out_stamp.day = yr_len;
            end
            dtfs_pkg::OP_MONTH:
            begin
                out_stamp.month = mo_new;
                if (sat.day > mo_len)
                    out_stamp.day = mo_len;
            end
            dtfs_pkg::OP_DAY:
                out_stamp = direction ? day_dn : day_up;
            dtfs_pkg::OP_HOUR:
            begin
                if (direction)
                begin
                    if (sat.hour > 5'd0)
                        out_stamp.hour = sat.hour - 5'd1;
                    else
                    begin
                        out_stamp      = day_dn;
                        out_stamp.hour = dtfs_pkg::LAST_HOUR;
                    end
                end
                else
                begin
                    if (sat.hour < dtfs_pkg::LAST_HOUR)
                        out_stamp.hour = sat.hour + 5'd1;
                    else
                    begin
                        out_stamp      = day_up;
                        out_stamp.hour = 5'd0;
                    end
                end
            end
            dtfs_pkg::OP_MINUTE:
            begin
                if (direction)
                begin
                    if (sat.minute > 6'd0)
                        out_stamp.minute = sat.minute - 6'd1;
                    else if (sat.hour > 5'd0)
                    begin
                        out_stamp.minute = dtfs_pkg::LAST_MINUTE;
                        out_stamp.hour   = sat.hour - 5'd1;
                    end
                    else
                    begin
                        out_stamp        = day_dn;
                        out_stamp.minute = dtfs_pkg::LAST_MINUTE;
                        out_stamp.hour   = dtfs_pkg::LAST_HOUR;
                    end
                end
                else
                begin
                    if (sat.minute < dtfs_pkg::LAST_MINUTE)
                        out_stamp.minute = sat.minute + 6'd1;
                    else if (sat.hour < dtfs_pkg::LAST_HOUR)
                    begin
                        out_stamp.minute = 6'd0;
                        out_stamp.hour   = sat.hour + 5'd1;
                    end
                    else
                    begin
                        out_stamp        = day_up;
                        out_stamp.minute = 6'd0;
                        out_stamp.hour   = 5'd0;
                    end
                end
            end
            dtfs_pkg::OP_SECOND:
                out_stamp.second = 6'd0;
            default:
            begin
                // unused selector: increment clears seconds, decrement holds
                if (!direction)
                    out_stamp.second = 6'd0;
            end
        endcase
    end

endmodule

[hw/rtl/dtfs_calc.sv]
// ----------------------------------------------------------------------------
// dtfs_calc
// weekday and zero-based day of year of a valid date in 2000..2099
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtfs_calc
(
    input  dtfs_pkg::stamp_t stamp,
    output logic [2:0]       week_day,
    output logic [8:0]       year_day
);

    logic       early;
    logic [6:0] k;
    logic [6:0] base;
    logic [3:0] mo_idx;
    logic [7:0] total;
    logic       leap_adj;

    // mod 7 by folding octal digits, since 8 mod 7 is 1
    function automatic logic [2:0] mod7(logic [7:0] v);
        logic [4:0] f1;
        logic [3:0] f2;
        f1 = {3'b000, v[7:6]} + {2'b00, v[5:3]} + {2'b00, v[2:0]};
        f2 = {2'b00, f1[4:3]} + {1'b0, f1[2:0]};
        return (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
    endfunction

    assign early  = (stamp.month < 4'd3);
    assign mo_idx = stamp.month - 4'd1;

    // years 2000..2099 reduce to k + k/4 mod 7; january and february of 2000
    // fall back into 1999, which leaves 5
    assign k    = stamp.year - {6'd0, early};
    assign base = (stamp.year == 7'd0 && early) ? 7'd5 : k + {2'b00, k[6:2]};

    assign total    = {1'b0, base} + {5'd0, dtfs_pkg::DOW_OFF[mo_idx]} + {3'd0, stamp.day};
    assign week_day = mod7(total);

    assign leap_adj = dtfs_pkg::is_leap(stamp.year) && !early;
    assign year_day = dtfs_pkg::DAYS_BEFORE[mo_idx] + {8'd0, leap_adj}
                    + {4'd0, stamp.day} - 9'd1;

endmodule

[hw/rtl/date_time_field_stepper_core.sv]
// ----------------------------------------------------------------------------
// date_time_field_stepper_core
// steps one field of a date-time with full calendar carry and reports the
// weekday and day of year of the result
// a taken start beat passes the input register and the result register, with
// one combinational pass between them, and leaves as the done beat
// throughput: one beat per cycle, busy stays low
// reset: rst_n clears the valid flags, payload registers keep
//   whatever they hold; the receiver cannot stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "date_time_field_stepper_core_macros.svh"

module date_time_field_stepper_core
(
    input  logic       clk,
    input  logic       rst_n,

    // command side
    input  logic       start,
    output logic       busy,
    input  logic [2:0] op,
    input  logic       direction,
    input  logic [6:0] in_year,
    input  logic [3:0] in_month,
    input  logic [4:0] in_day,
    input  logic [4:0] in_hour,
    input  logic [5:0] in_minute,
    input  logic [5:0] in_second,

    // result side, one-cycle strobe
    output logic       done,
    output logic [6:0] out_year,
    output logic [3:0] out_month,
    output logic [4:0] out_day,
    output logic [4:0] out_hour,
    output logic [5:0] out_minute,
    output logic [5:0] out_second,
    output logic [2:0] week_day,
    output logic [8:0] year_day
);

    // stage 1: captured command
    logic             vld1_reg;
    logic [2:0]       op_reg;
    logic             dir_reg;
    dtfs_pkg::stamp_t in_reg;

    // stepped date-time, combinational
    dtfs_pkg::stamp_t step_next;

    // stage 2: result beat
    logic             done_reg;
    dtfs_pkg::stamp_t res_reg;
    logic [2:0]       wday_reg;
    logic [2:0]       wday_next;
    logic [8:0]       yday_reg;
    logic [8:0]       yday_next;

    // length of the delivered month, checked below
    logic [4:0]       day_len;

    // every stage moves each cycle, so a new beat is always welcome
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // valid pipeline, the only state that reset touches
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= start && !busy;
            done_reg <= vld1_reg;
        end
    end

    // ------------------------------------------------------------------
    // input register: capture the command beat as it is accepted
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg         <= op;
            dir_reg        <= direction;
            in_reg.year    <= in_year;
            in_reg.month   <= in_month;
            in_reg.day     <= in_day;
            in_reg.hour    <= in_hour;
            in_reg.minute  <= in_minute;
            in_reg.second  <= in_second;
        end
    end

    // ------------------------------------------------------------------
    // saturate and step; the stepped value is always a valid date-time
    // ------------------------------------------------------------------
    dtfs_step u_step
    (
        .op        (op_reg),
        .direction (dir_reg),
        .in_stamp  (in_reg),
        .out_stamp (step_next)
    );

    // ------------------------------------------------------------------
    // weekday and day of year from the stepped date
    // ------------------------------------------------------------------
    dtfs_calc u_calc
    (
        .stamp    (step_next),
        .week_day (wday_next),
        .year_day (yday_next)
    );

    always_ff @(posedge clk)
    begin
        if (vld1_reg)
        begin
            res_reg  <= step_next;
            wday_reg <= wday_next;
            yday_reg <= yday_next;
        end
    end

    // result ports straight from the output register
    assign done       = done_reg;
    assign out_year   = res_reg.year;
    assign out_month  = res_reg.month;
    assign out_day    = res_reg.day;
    assign out_hour   = res_reg.hour;
    assign out_minute = res_reg.minute;
    assign out_second = res_reg.second;
    assign week_day   = wday_reg;
    assign year_day   = yday_reg;

    assign day_len = dtfs_pkg::month_days(out_year, out_month);

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // an accepted beat leaves the pipeline as exactly one strobe, one stage on
    `DTFS_ASSERT_NEXT(a_accept_to_done, clk, rst_n, vld1_reg, done_reg)
    `DTFS_ASSERT_NEXT(a_no_spurious_done, clk, rst_n, !vld1_reg, !done_reg)
    // the delivered day always fits the delivered month and year
    `DTFS_ASSERT_SAME(a_day_in_month, clk, rst_n, done, (out_day >= 5'd1) && (out_day <= day_len))
    // weekday and day of year stay within their calendar ranges
    `DTFS_ASSERT_SAME(a_calc_range, clk, rst_n, done, (week_day <= 3'd6) && (year_day <= 9'd365))

endmodule
